>>> hw/rtl/wah_enc_pkg.sv
// Shared constants and types of the WAH bitmap encoder.
`timescale 1ns / 1ps
`default_nettype none
package wah_enc_pkg;

  // Width of one raw bitmap word and of one code word.
  localparam int unsigned WordW    = 64;
  // Bits in one group. A literal code word carries exactly this many bits.
  localparam int unsigned GroupBits = 63;
  // Width of the bitmap length register.
  localparam int unsigned TotalW   = 41;
  // Width of the group count held in a fill word.
  localparam int unsigned FillCntW = 62;
  // Width of the carry count, and the most bits that can stay in the carry.
  localparam int unsigned CarryCntW = 6;
  localparam int unsigned CarryMax  = GroupBits - 1;

  // At most two groups and one flush come from one item.
  localparam int unsigned ResMax  = 3;
  localparam int unsigned ResCntW = 2;

  // Output queue geometry.
  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = 2;
  localparam int unsigned QCntW  = 3;

  // APB register map: one 64-bit register, so the index is address bit 3.
  localparam int unsigned AddrW    = 4;
  localparam int unsigned ApbDataW = 64;
  localparam logic        RegTotalBits = 1'b0;
  localparam logic [TotalW-1:0] TotalBitsReset = 41'd64;

  // One result item.
  typedef struct packed {
    logic [WordW-1:0] code_word;
    logic             last;
  } code_item_t;

  // Running encoder state between items.
  typedef struct packed {
    logic [CarryMax-1:0]  carry_bits;
    logic [CarryCntW-1:0] carry_count;
    logic [TotalW-1:0]    group_start;
    logic [WordW-1:0]     held_word;
    logic                 held_valid;
  } enc_state_t;

  // Result items produced for one input item, packed from slot 0 upward.
  typedef struct packed {
    logic [ResCntW-1:0]           cnt;
    code_item_t [ResMax-1:0]      item;
  } push_t;

endpackage
`default_nettype wire

>>> hw/rtl/wah_enc_ifs.sv
// Valid/ready channel interfaces for raw bitmap words and WAH code words.
`timescale 1ns / 1ps
`default_nettype none
interface wah_raw_if;
  logic        valid;
  logic        ready;
  logic [63:0] raw_word;
  logic        last_word;

  modport source (output valid, output raw_word, output last_word, input ready);
  modport sink   (input valid, input raw_word, input last_word, output ready);
endinterface

interface wah_code_if;
  logic        valid;
  logic        ready;
  logic [63:0] code_word;
  logic        last;

  modport source (output valid, output code_word, output last, input ready);
  modport sink   (input valid, input code_word, input last, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/wah_enc_step.sv
// Combinational coding of one raw word: grouping, fill merging and flush.
`timescale 1ns / 1ps
`default_nettype none
module wah_enc_step
  import wah_enc_pkg::*;
(
  input  enc_state_t             state_i,
  input  logic [TotalW-1:0]      total_bits_i,
  input  logic [WordW-1:0]       raw_word_i,
  input  logic                   last_word_i,
  output enc_state_t             state_o,
  output push_t                  push_o
);

  typedef struct packed {
    logic             emit;
    logic [WordW-1:0] emit_word;
    logic [WordW-1:0] held_word;
    logic             held_valid;
  } grp_res_t;

  // Zeroes the bits of a group that lie at or beyond the end of the bitmap.
  function automatic logic [GroupBits-1:0] clip_group(
    input logic [GroupBits-1:0] v,
    input logic [TotalW-1:0]    gs,
    input logic [TotalW-1:0]    total
  );
    logic [TotalW-1:0] rem;
    rem = total - gs;
    if (rem < TotalW'(GroupBits)) begin
      return v & ~({GroupBits{1'b1}} << rem[CarryCntW-1:0]);
    end
    return v;
  endfunction

  // Start of the following group, saturating at the bitmap length.
  function automatic logic [TotalW-1:0] next_start(
    input logic [TotalW-1:0] gs,
    input logic [TotalW-1:0] total
  );
    logic [TotalW-1:0] rem;
    rem = total - gs;
    if (rem > TotalW'(GroupBits)) begin
      return gs + TotalW'(GroupBits);
    end
    return total;
  endfunction

  // Codes one group against the held word.
  function automatic grp_res_t code_group(
    input logic [GroupBits-1:0] v,
    input logic [WordW-1:0]     hw,
    input logic                 hv
  );
    grp_res_t r;
    logic     is_fill;
    logic     ones;
    ones    = &v;
    is_fill = (v == '0) || ones;
    r.emit       = 1'b0;
    r.emit_word  = hw;
    r.held_word  = hw;
    r.held_valid = hv;
    if (is_fill && hv && hw[WordW-1] && (hw[WordW-2] == ones) && !(&hw[FillCntW-1:0])) begin
      r.held_word = hw + WordW'(1);
    end else begin
      r.emit       = hv;
      r.held_word  = is_fill ? {1'b1, ones, FillCntW'(1)} : {1'b0, v};
      r.held_valid = 1'b1;
    end
    return r;
  endfunction

  logic [CarryCntW-1:0]   c;
  logic [2*WordW-1:0]     win;
  logic [GroupBits-1:0]   grp_a;
  logic [GroupBits-1:0]   grp_b;
  logic                   a_en;
  logic                   b_en;
  logic [TotalW-1:0]      gs_a;
  logic [TotalW-1:0]      gs_b;
  grp_res_t               res_a;
  grp_res_t               res_b;
  logic                   flush;
  code_item_t             item_a;
  code_item_t             item_b;
  code_item_t             item_f;

  // The carry never holds 63 bits; a count of 63 is read as empty.
  assign c   = (state_i.carry_count == '1) ? '0 : state_i.carry_count;
  assign win = {{(2*WordW-CarryMax){1'b0}}, state_i.carry_bits}
             | ({{WordW{1'b0}}, raw_word_i} << c);

  // The first group always has enough bits; the second one has them only
  // with a full carry, or as the padded leftover group at the end.
  assign a_en = state_i.group_start < total_bits_i;
  assign gs_a = a_en ? next_start(state_i.group_start, total_bits_i) : state_i.group_start;
  assign b_en = a_en && (gs_a < total_bits_i) && ((c >= CarryCntW'(CarryMax)) || last_word_i);
  assign gs_b = b_en ? next_start(gs_a, total_bits_i) : gs_a;

  assign grp_a = clip_group(win[GroupBits-1:0], state_i.group_start, total_bits_i);
  assign grp_b = clip_group(win[2*GroupBits-1:GroupBits], gs_a, total_bits_i);

  always_comb begin
    if (a_en) begin
      res_a = code_group(grp_a, state_i.held_word, state_i.held_valid);
    end else begin
      res_a = '{emit: 1'b0, emit_word: state_i.held_word,
                held_word: state_i.held_word, held_valid: state_i.held_valid};
    end
    if (b_en) begin
      res_b = code_group(grp_b, res_a.held_word, res_a.held_valid);
    end else begin
      res_b = '{emit: 1'b0, emit_word: res_a.held_word,
                held_word: res_a.held_word, held_valid: res_a.held_valid};
    end
  end

  assign flush  = last_word_i && res_b.held_valid;
  assign item_a = '{code_word: res_a.emit_word, last: 1'b0};
  assign item_b = '{code_word: res_b.emit_word, last: 1'b0};
  assign item_f = '{code_word: res_b.held_word, last: 1'b1};

  // Pack the produced items in order into the low slots.
  always_comb begin
    push_o.cnt     = ResCntW'({1'b0, res_a.emit} + {1'b0, res_b.emit} + {1'b0, flush});
    push_o.item[0] = res_a.emit ? item_a : (res_b.emit ? item_b : item_f);
    push_o.item[1] = (res_a.emit && res_b.emit) ? item_b : item_f;
    push_o.item[2] = item_f;
  end

  always_comb begin
    state_o = '0;
    if (!last_word_i) begin
      state_o.group_start = gs_b;
      state_o.held_word   = res_b.held_word;
      state_o.held_valid  = res_b.held_valid;
      if ((gs_b < total_bits_i) && !b_en) begin
        state_o.carry_count = c + CarryCntW'(1);
        state_o.carry_bits  = win[GroupBits+CarryMax-1:GroupBits];
      end
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/wah_enc_outq.sv
// Small result queue that takes up to three code words per cycle.
`timescale 1ns / 1ps
`default_nettype none
module wah_enc_outq
  import wah_enc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  push_t      push_i,
  input  logic       pop_i,
  output code_item_t head_o,
  output logic       valid_o,
  output logic       room_o
);

  code_item_t       mem [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0] count_q, count_d;

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < ResMax; k++) begin
      if (ResCntW'(k) < push_i.cnt) begin
        mem[wr_ptr_q + QPtrW'(k)] <= push_i.item[k];
      end
    end
  end

  assign wr_ptr_d = wr_ptr_q + QPtrW'(push_i.cnt);
  assign rd_ptr_d = rd_ptr_q + QPtrW'(pop_i);
  assign count_d  = count_q + QCntW'(push_i.cnt) - QCntW'(pop_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  assign head_o  = mem[rd_ptr_q];
  assign valid_o = count_q != '0;
  // A full item may add three words, so at most one may wait beforehand.
  assign room_o  = count_q <= QCntW'(QDepth - ResMax);

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= QCntW'(QDepth))
    else $error("result queue count exceeds its depth");

  a_push_fits : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i.cnt != '0) |-> room_o)
    else $error("result words pushed without room in the queue");

endmodule
`default_nettype wire

>>> hw/rtl/wah_bitmap_encoder_core.sv
// Top level of the WAH bitmap encoder: input register, state, APB register and result queue.
`timescale 1ns / 1ps
`default_nettype none
// Streaming Word-Aligned Hybrid encoder for 64-bit raw bitmap words. Each raw
// word (bit 0 first) is regrouped into 63-bit groups; all-zero and all-one
// groups extend a held fill word, other groups become literal words, and the
// held word goes out when a different word replaces it. The item marked
// last_word closes the bitmap: the leftover bits form one zero-padded group,
// the held word is sent with last set, and the stream state clears. The
// bitmap length total_bits is an APB register at address 0 (reset 64); write
// it only while the block is idle. Rate: one raw word can be accepted every
// cycle while the result queue has room. A word is held in the input
// register, where the grouping and fill merging are done in a single pass,
// and its code words enter a four-entry result queue at the edge where the
// word leaves that register. The first of them is offered on the output
// right after that edge. The output port drains one code word per cycle
// while the consumer is ready; the input register moves on only while at
// most one code word is waiting, so a word is taken every cycle as long as
// each word yields at most one code word and the output keeps up. A word
// that yields more holds the input until the queue has drained back to one
// waiting code word.
module wah_bitmap_encoder_core
  import wah_enc_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  wah_raw_if.sink             in_ch,
  wah_code_if.source          out_ch,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [AddrW-1:0]    paddr,
  input  logic [ApbDataW-1:0] pwdata,
  output logic [ApbDataW-1:0] prdata,
  output logic                pready
);

  logic                in_valid_q, in_valid_d;
  logic [WordW-1:0]    raw_q;
  logic                last_q;
  logic [TotalW-1:0]   total_q;
  enc_state_t          state_q;
  enc_state_t          state_d;
  push_t               step_push;
  push_t               q_push;
  code_item_t          q_head;
  logic                q_valid;
  logic                q_room;
  logic                advance;
  logic                accept;
  logic                pop;
  logic                cfg_wr;

  // The input register hands its word to the coding logic whenever the
  // queue can take everything that word may produce.
  assign advance     = in_valid_q && q_room;
  assign in_ch.ready = !in_valid_q || advance;
  assign accept      = in_ch.valid && in_ch.ready;
  assign in_valid_d  = accept || (in_valid_q && !advance);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      raw_q  <= in_ch.raw_word;
      last_q <= in_ch.last_word;
    end
  end

  wah_enc_step u_step (
    .state_i      (state_q),
    .total_bits_i (total_q),
    .raw_word_i   (raw_q),
    .last_word_i  (last_q),
    .state_o      (state_d),
    .push_o       (step_push)
  );

  // Stream state moves only when a word is actually coded.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  always_comb begin
    q_push = step_push;
    if (!advance) begin
      q_push.cnt = '0;
    end
  end

  assign pop = out_ch.valid && out_ch.ready;

  wah_enc_outq u_outq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .pop_i   (pop),
    .head_o  (q_head),
    .valid_o (q_valid),
    .room_o  (q_room)
  );

  assign out_ch.valid     = q_valid;
  assign out_ch.code_word = q_head.code_word;
  assign out_ch.last      = q_head.last;

  // APB register: zero wait states, writes on the access phase.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[3] == RegTotalBits);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= TotalBitsReset;
    end else if (cfg_wr) begin
      total_q <= pwdata[TotalW-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[3] == RegTotalBits) begin
      prdata = {{(ApbDataW-TotalW){1'b0}}, total_q};
    end
  end

  a_last_clears : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && last_q) |=> (state_q.carry_count == '0) && !state_q.held_valid
                            && (state_q.group_start == '0))
    else $error("stream state not cleared after the last word");

  a_carry_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.carry_count <= CarryCntW'(CarryMax))
    else $error("carry holds a full group or more");

endmodule
`default_nettype wire
